[rtl/kgr_pkg.sv]
package kgr_pkg;

    localparam int MAP_REGS = 4;
    localparam int CFG_W    = 18;
    localparam int CFG_IW   = 3;
    localparam int TIME_W   = 32;
    localparam int CODE_W   = 10;
    localparam int ID_W     = 8;

    // register indexes on the config port
    localparam logic [CFG_IW-1:0] REG_LONG_PRESS   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_DOUBLE_CLICK = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DEBOUNCE     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_MAP_0        = 3'd3;
    localparam logic [CFG_IW-1:0] REG_MAP_1        = 3'd4;
    localparam logic [CFG_IW-1:0] REG_MAP_2        = 3'd5;
    localparam logic [CFG_IW-1:0] REG_MAP_3        = 3'd6;

    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [15:0] DOUBLE_CLICK_RST = 16'd300;
    localparam logic [15:0] DEBOUNCE_RST     = 16'd20;

    // request types and key values
    localparam logic       REQ_KEY     = 1'b0;
    localparam logic       REQ_TICK    = 1'b1;
    localparam logic [1:0] VAL_RELEASE = 2'd0;
    localparam logic [1:0] VAL_PRESS   = 2'd1;
    localparam logic [1:0] VAL_REPEAT  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRESSED = 3'd1,
        PH_WAIT2   = 3'd2,
        PH_LONG    = 3'd3,
        PH_PRESS2  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_LONG   = 2'd1,
        KIND_DOUBLE = 2'd2
    } gesture_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_CALC,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ID_W-1:0]   id;
        phase_t            phase;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] release_stamp;
    } slot_rec_t;

    typedef struct packed {
        logic [ID_W-1:0]   key;
        gesture_kind_t     kind;
        logic [TIME_W-1:0] hold;
    } gesture_t;

endpackage

[rtl/kgr_ram.sv]
module kgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/key_gesture_recognizer.sv]
// key gesture recognizer: short press, long press and double click per key.
// a request is either a key event or a time tick, taken when start is high
// and busy is low. results come out as one-cycle strobes on result_valid;
// the receiver cannot stall them, so it must take every strobe as it comes.
// last_of_run marks the final result of a request. slot records live in a
// single-port ram with registered read, and one shared subtractor works out
// elapsed time, so the block walks the slots one at a time: a tick reads every
// slot in use and works out the elapsed time for each one that is pressed or
// waiting for a second press; a key event reads slots in creation order until
// its code matches, creates a new slot when no code matches and the table has
// room, and finishes with no change when its code is new and the table is full;
// an auto-repeat goes straight to the finishing state. no clearing pass follows
// reset: only slots already created are ever read.
module key_gesture_recognizer
    import kgr_pkg::*;
#(
    parameter int KEY_SLOTS   = 8,
    parameter int MAP_ENTRIES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic [CODE_W-1:0]    key_code,
    input  logic [1:0]           key_value,
    input  logic [TIME_W-1:0]    time_ms,
    // result channel
    output logic                 result_valid,
    output logic [ID_W-1:0]      gesture_key,
    output logic [1:0]           gesture_kind,
    output logic [TIME_W-1:0]    hold_ms,
    output logic                 last_of_run,
    // config write port
    input  logic                 cfg_we,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int SLOT_AW  = KEY_SLOTS > 1 ? $clog2(KEY_SLOTS) : 1;
    localparam int CNT_W    = $clog2(KEY_SLOTS + 1);
    localparam int MAP_USED = MAP_ENTRIES < MAP_REGS ? MAP_ENTRIES : MAP_REGS;
    localparam int REC_W    = $bits(slot_rec_t);

    // config registers
    logic [15:0]      long_press_reg;
    logic [15:0]      double_click_reg;
    logic [15:0]      debounce_reg;
    logic [CFG_W-1:0] map_reg [MAP_REGS];

    // sequencer and working registers
    state_t              state_reg, state_next;
    logic                req_type_reg;
    logic [CODE_W-1:0]   key_code_reg;
    logic [1:0]          key_value_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    slot_rec_t           rec_reg, rec_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;

    // one result is held back until the next one shows whether it was last
    logic                pend_valid_reg, pend_valid_next;
    gesture_t            pend_reg, pend_next;

    logic                result_valid_reg, result_valid_next;
    gesture_t            result_reg, result_next;
    logic                last_reg, last_next;

    // slot ram
    logic                ram_we;
    logic [SLOT_AW-1:0]  ram_addr;
    slot_rec_t           ram_wrec;
    logic [REC_W-1:0]    ram_rdata;
    slot_rec_t           ram_rrec;

    logic                accept;
    logic                at_end;
    logic                is_tick;
    logic [ID_W-1:0]     map_id;
    logic                map_found;
    logic [TIME_W-1:0]   earlier;
    logic [TIME_W:0]     diff;
    slot_rec_t           upd;
    logic                res_hit;
    gesture_t            res;

    assign accept   = start && (state_reg == ST_IDLE);
    assign at_end   = (idx_reg == used_reg);
    assign is_tick  = (req_type_reg == REQ_TICK);
    assign ram_addr = idx_reg[SLOT_AW-1:0];
    assign ram_rrec = slot_rec_t'(ram_rdata);

    kgr_ram #(
        .WIDTH (REC_W),
        .DEPTH (KEY_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (REC_W'(ram_wrec)),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // map lookup for a new slot, first matching entry wins
    always_comb
    begin
        map_id    = '0;
        map_found = 1'b0;
        for (int i = 0; i < MAP_USED; i++)
        begin
            if (!map_found && (map_reg[i][CFG_W-1:ID_W] == key_code_reg))
            begin
                map_id    = map_reg[i][ID_W-1:0];
                map_found = 1'b1;
            end
        end
    end

    // shared elapsed-time unit: later minus earlier, clamped at zero
    assign earlier = (rec_reg.phase == PH_WAIT2) ? rec_reg.release_stamp
                                                 : rec_reg.press_stamp;
    assign diff    = {1'b0, time_reg} - {1'b0, earlier};

    // per-slot phase update from the elapsed time
    always_comb
    begin
        upd     = rec_reg;
        res_hit = 1'b0;
        res     = '{key: rec_reg.id, kind: KIND_SHORT, hold: '0};
        if (is_tick)
        begin
            if (rec_reg.phase == PH_PRESSED)
            begin
                if (elapsed_reg >= TIME_W'(long_press_reg))
                begin
                    upd.phase = PH_LONG;
                    res_hit   = 1'b1;
                    res.kind  = KIND_LONG;
                    res.hold  = elapsed_reg;
                end
            end
            else if (rec_reg.phase == PH_WAIT2)
            begin
                if (elapsed_reg >= TIME_W'(double_click_reg))
                begin
                    upd.phase = PH_IDLE;
                    res_hit   = 1'b1;
                end
            end
        end
        else if (rec_reg.id != '0)
        begin
            if (key_value_reg == VAL_PRESS)
            begin
                if (rec_reg.phase == PH_IDLE)
                begin
                    upd.phase       = PH_PRESSED;
                    upd.press_stamp = time_reg;
                end
                else if (rec_reg.phase == PH_WAIT2)
                begin
                    upd.phase       = (elapsed_reg <= TIME_W'(double_click_reg))
                                      ? PH_PRESS2 : PH_PRESSED;
                    upd.press_stamp = time_reg;
                end
            end
            else if (key_value_reg == VAL_RELEASE)
            begin
                if (rec_reg.phase == PH_PRESSED)
                begin
                    if (elapsed_reg < TIME_W'(debounce_reg))
                    begin
                        upd.phase = PH_IDLE;
                    end
                    else if (elapsed_reg >= TIME_W'(long_press_reg))
                    begin
                        upd.phase = PH_IDLE;
                        res_hit   = 1'b1;
                        res.kind  = KIND_LONG;
                        res.hold  = elapsed_reg;
                    end
                    else
                    begin
                        upd.phase         = PH_WAIT2;
                        upd.release_stamp = time_reg;
                    end
                end
                else if (rec_reg.phase == PH_PRESS2)
                begin
                    upd.phase = PH_IDLE;
                    res_hit   = 1'b1;
                    res.kind  = KIND_DOUBLE;
                    res.hold  = elapsed_reg;
                end
                else if (rec_reg.phase == PH_LONG)
                begin
                    upd.phase = PH_IDLE;
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_KEY && key_value == VAL_REPEAT)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (!at_end)
                begin
                    state_next = ST_CHECK;
                end
                else if (is_tick || used_reg == CNT_W'(KEY_SLOTS))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CHECK:
            begin
                if (is_tick)
                begin
                    state_next = (ram_rrec.phase == PH_PRESSED ||
                                  ram_rrec.phase == PH_WAIT2) ? ST_CALC : ST_READ;
                end
                else
                begin
                    state_next = (ram_rrec.code == key_code_reg) ? ST_CALC : ST_READ;
                end
            end
            ST_CALC:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = is_tick ? ST_READ : ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result outputs
    always_comb
    begin
        idx_next          = idx_reg;
        used_next         = used_reg;
        rec_next          = rec_reg;
        elapsed_next      = elapsed_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        last_next         = last_reg;
        ram_we            = 1'b0;
        ram_wrec          = upd;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
            end
            ST_READ:
            begin
                // no match among existing slots: build a fresh one here
                if (at_end && !is_tick && used_reg != CNT_W'(KEY_SLOTS))
                begin
                    rec_next  = '{code: key_code_reg, id: map_id, phase: PH_IDLE,
                                  press_stamp: '0, release_stamp: '0};
                    used_next = used_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                rec_next = ram_rrec;
                if (state_next == ST_READ)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CALC:
            begin
                elapsed_next = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
            end
            ST_DECIDE:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (res_hit)
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next = 1'b1;
                        result_next       = pend_reg;
                        last_next         = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = res;
                end
            end
            ST_FINISH:
            begin
                if (pend_valid_reg)
                begin
                    result_valid_next = 1'b1;
                    result_next       = pend_reg;
                    last_next         = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            used_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            long_press_reg   <= LONG_PRESS_RST;
            double_click_reg <= DOUBLE_CLICK_RST;
            debounce_reg     <= DEBOUNCE_RST;
            for (int i = 0; i < MAP_REGS; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            used_reg         <= used_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LONG_PRESS:   long_press_reg   <= cfg_wdata[15:0];
                    REG_DOUBLE_CLICK: double_click_reg <= cfg_wdata[15:0];
                    REG_DEBOUNCE:     debounce_reg     <= cfg_wdata[15:0];
                    REG_MAP_0:        map_reg[0]       <= cfg_wdata;
                    REG_MAP_1:        map_reg[1]       <= cfg_wdata;
                    REG_MAP_2:        map_reg[2]       <= cfg_wdata;
                    REG_MAP_3:        map_reg[3]       <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg  <= req_type;
            key_code_reg  <= key_code;
            key_value_reg <= key_value;
            time_reg      <= time_ms;
        end
        rec_reg     <= rec_next;
        elapsed_reg <= elapsed_next;
        pend_reg    <= pend_next;
        result_reg  <= result_next;
        last_reg    <= last_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign gesture_key  = result_reg.key;
    assign gesture_kind = result_reg.kind;
    assign hold_ms      = result_reg.hold;
    assign last_of_run  = last_reg;

endmodule

[tb/sv/tb_key_gesture_recognizer.sv]
module tb_key_gesture_recognizer;
    import kgr_pkg::*;

    // table size of the block as built here
    localparam int SLOTS = 8;
    // kept above the longest busy stretch of one request, with margin
    localparam int SETTLE_CYCLES = 40;
    // far above the slowest legal run of this sequence
    localparam int CYCLE_LIMIT = 300000;
    // index past the last register, which the block must ignore
    localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;
    // key value that only finds or creates a slot
    localparam logic [1:0] VAL_SLOT_ONLY = 2'd3;

    // raw key codes used by the directed tests, in the order their slots appear (repeat and late get none)
    localparam logic [CODE_W-1:0] KEY_UNMAPPED = 10'd5;
    localparam logic [CODE_W-1:0] KEY_REPEAT   = 10'd6;
    localparam logic [CODE_W-1:0] KEY_ZERO     = 10'd0;
    localparam logic [CODE_W-1:0] KEY_TOP      = 10'd767;
    localparam logic [CODE_W-1:0] KEY_MID      = 10'd300;
    localparam logic [CODE_W-1:0] KEY_ODD      = 10'h155;
    localparam logic [CODE_W-1:0] KEY_E        = 10'd1;
    localparam logic [CODE_W-1:0] KEY_F        = 10'd512;
    localparam logic [CODE_W-1:0] KEY_G        = 10'd2;
    localparam logic [CODE_W-1:0] KEY_LATE     = 10'd3;

    typedef struct packed {
        logic [ID_W-1:0]   key;
        gesture_kind_t     kind;
        logic [TIME_W-1:0] hold;
        logic              last;
    } gesture_exp_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 req_type;
    logic [CODE_W-1:0]    key_code;
    logic [1:0]           key_value;
    logic [TIME_W-1:0]    time_ms;
    logic                 result_valid;
    logic [ID_W-1:0]      gesture_key;
    logic [1:0]           gesture_kind;
    logic [TIME_W-1:0]    hold_ms;
    logic                 last_of_run;
    logic                 cfg_we;
    logic [CFG_IW-1:0]    cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    key_gesture_recognizer #(
        .KEY_SLOTS   (SLOTS),
        .MAP_ENTRIES (MAP_REGS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .key_code     (key_code),
        .key_value    (key_value),
        .time_ms      (time_ms),
        .result_valid (result_valid),
        .gesture_key  (gesture_key),
        .gesture_kind (gesture_kind),
        .hold_ms      (hold_ms),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // gestures predicted but not yet seen on the result port, oldest first
    gesture_exp_t gesture_q [$];

    int errors;
    int requests_sent;
    int idle_pct;
    int cycle_count;
    logic [TIME_W-1:0] now_ms;

    // own copy of the block configuration
    logic [15:0]       long_ms;
    logic [15:0]       dbl_ms;
    logic [15:0]       bounce_ms;
    logic [CFG_W-1:0]  map_regs [MAP_REGS];

    // own copy of the slot table
    logic [CODE_W-1:0] slot_code [SLOTS];
    logic [ID_W-1:0]   slot_id [SLOTS];
    phase_t            slot_phase [SLOTS];
    logic [TIME_W-1:0] slot_press [SLOTS];
    logic [TIME_W-1:0] slot_release [SLOTS];
    int                slots_used;

    // codes the random part draws from: the mapped slots, one unmapped slot
    // and one code that arrives after the table is full
    logic [CODE_W-1:0] key_pool [9] = '{KEY_ZERO, KEY_TOP, KEY_MID, KEY_ODD,
                                        KEY_E, KEY_F, KEY_G, KEY_UNMAPPED, KEY_LATE};

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    // elapsed time that saturates at zero when the later stamp is the smaller one
    function automatic logic [TIME_W-1:0] ms_since(input logic [TIME_W-1:0] later,
                                                   input logic [TIME_W-1:0] earlier);
        return (later >= earlier) ? later - earlier : 32'd0;
    endfunction

    // first map entry whose code matches wins, no match means unmapped
    function automatic logic [ID_W-1:0] lookup_id(input logic [CODE_W-1:0] code);
        for (int i = 0; i < MAP_REGS; i++)
            if (map_regs[i][CFG_W-1:ID_W] == code)
                return map_regs[i][ID_W-1:0];
        return '0;
    endfunction

    // slot of a code, made on first sight; -1 when new and the table is full
    function automatic int slot_of(input logic [CODE_W-1:0] code);
        int n;
        for (int i = 0; i < slots_used; i++)
            if (slot_code[i] == code)
                return i;
        if (slots_used >= SLOTS)
            return -1;
        n = slots_used;
        slot_code[n] = code;
        slot_id[n] = lookup_id(code);
        slot_phase[n] = PH_IDLE;
        slot_press[n] = '0;
        slot_release[n] = '0;
        slots_used++;
        return n;
    endfunction

    // advance the slot table by one request and queue the gestures it reports
    function automatic void predict_gestures(input logic rt, input logic [CODE_W-1:0] code,
                                             input logic [1:0] val,
                                             input logic [TIME_W-1:0] t);
        gesture_exp_t run [$];
        logic [TIME_W-1:0] d;
        int s;
        if (rt == REQ_TICK)
        begin
            // walk slots in creation order, at most one gesture each
            for (int i = 0; i < slots_used; i++)
            begin
                if (slot_phase[i] == PH_PRESSED)
                begin
                    d = ms_since(t, slot_press[i]);
                    if (d >= long_ms)
                    begin
                        slot_phase[i] = PH_LONG;
                        run.push_back(gesture_exp_t'{slot_id[i], KIND_LONG, d, 1'b0});
                    end
                end
                else if (slot_phase[i] == PH_WAIT2 && ms_since(t, slot_release[i]) >= dbl_ms)
                begin
                    slot_phase[i] = PH_IDLE;
                    run.push_back(gesture_exp_t'{slot_id[i], KIND_SHORT, 32'd0, 1'b0});
                end
            end
        end
        else if (val != VAL_REPEAT)
        begin
            s = slot_of(code);
            if (s >= 0 && slot_id[s] != '0)
            begin
                d = ms_since(t, slot_press[s]);
                if (val == VAL_PRESS)
                begin
                    if (slot_phase[s] == PH_IDLE)
                    begin
                        slot_phase[s] = PH_PRESSED;
                        slot_press[s] = t;
                    end
                    else if (slot_phase[s] == PH_WAIT2)
                    begin
                        slot_phase[s] = (ms_since(t, slot_release[s]) <= dbl_ms) ?
                                        PH_PRESS2 : PH_PRESSED;
                        slot_press[s] = t;
                    end
                end
                else if (val == VAL_RELEASE)
                begin
                    case (slot_phase[s])
                        PH_PRESSED:
                        begin
                            if (d < bounce_ms)
                                slot_phase[s] = PH_IDLE;
                            else if (d >= long_ms)
                            begin
                                slot_phase[s] = PH_IDLE;
                                run.push_back(gesture_exp_t'{slot_id[s], KIND_LONG, d, 1'b0});
                            end
                            else
                            begin
                                slot_phase[s] = PH_WAIT2;
                                slot_release[s] = t;
                            end
                        end
                        PH_PRESS2:
                        begin
                            slot_phase[s] = PH_IDLE;
                            run.push_back(gesture_exp_t'{slot_id[s], KIND_DOUBLE, d, 1'b0});
                        end
                        PH_LONG:
                            slot_phase[s] = PH_IDLE;
                        default:
                            ;
                    endcase
                end
            end
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            gesture_q.push_back(run[i]);
    endfunction

    // one request: optional idle gap, then hold start until the block takes it.
    // start is left high on return so a back-to-back request keeps it high
    task automatic send_request(input logic rt, input logic [CODE_W-1:0] code,
                                input logic [1:0] val, input logic [TIME_W-1:0] t);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rt;
        key_code <= code;
        key_value <= val;
        time_ms <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // taken at this edge
        predict_gestures(rt, code, val, t);
        requests_sent++;
    endtask

    // ticks carry junk in the key fields, which the block must not look at
    task automatic tick_at(input logic [TIME_W-1:0] t);
        send_request(REQ_TICK, CODE_W'($urandom_range(767)), 2'($urandom_range(3)), t);
    endtask

    // drop start and wait until every predicted gesture is in and the block is idle
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (gesture_q.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_we high; the callers below lower it after their last write
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx) inside
            REG_LONG_PRESS:   long_ms = data[15:0];
            REG_DOUBLE_CLICK: dbl_ms = data[15:0];
            REG_DEBOUNCE:     bounce_ms = data[15:0];
            REG_MAP_0, REG_MAP_1, REG_MAP_2, REG_MAP_3:
                map_regs[idx - REG_MAP_0] = data;
            default:
                ;
        endcase
    endtask

    // timing registers, with junk in the bits above the 16 that count
    task automatic set_timing(input logic [15:0] l, input logic [15:0] d,
                              input logic [15:0] b);
        logic [1:0] pad;
        pad = 2'($urandom_range(3));
        write_reg(REG_LONG_PRESS, {pad, l});
        pad = 2'($urandom_range(3));
        write_reg(REG_DOUBLE_CLICK, {pad, d});
        pad = 2'($urandom_range(3));
        write_reg(REG_DEBOUNCE, {pad, b});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // all four map entries, plus a write past the last index that must do nothing
    task automatic set_map(input logic [CFG_W-1:0] m0, input logic [CFG_W-1:0] m1,
                           input logic [CFG_W-1:0] m2, input logic [CFG_W-1:0] m3);
        write_reg(REG_MAP_0, m0);
        write_reg(REG_MAP_1, m1);
        write_reg(REG_MAP_2, m2);
        write_reg(REG_MAP_3, m3);
        write_reg(REG_UNUSED, CFG_W'($urandom_range(18'h3FFFF)));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // step size for the random part: mostly close to one of the three windows
    function automatic logic [TIME_W-1:0] pick_gap_ms();
        logic [TIME_W-1:0] mark_ms;
        case ($urandom_range(2))
            0:       mark_ms = bounce_ms;
            1:       mark_ms = dbl_ms;
            default: mark_ms = long_ms;
        endcase
        case ($urandom_range(3))
            0:       return $urandom_range(40);
            1, 2:    return (mark_ms < 3) ? mark_ms + $urandom_range(2) :
                                            mark_ms - 2 + $urandom_range(4);
            default: return $urandom_range(2 * long_ms + 50);
        endcase
    endfunction

    task automatic key_later(input logic [CODE_W-1:0] code, input logic [1:0] val);
        now_ms += pick_gap_ms();
        send_request(REQ_KEY, code, val, now_ms);
    endtask

    task automatic tick_later();
        now_ms += pick_gap_ms();
        tick_at(now_ms);
    endtask

    // defaults after reset: every key is unmapped, and auto-repeat makes no slot
    task automatic test_unmapped_and_repeat();
        send_request(REQ_KEY, KEY_UNMAPPED, VAL_PRESS, 32'd100);
        send_request(REQ_KEY, KEY_REPEAT, VAL_REPEAT, 32'd150);
        send_request(REQ_KEY, KEY_UNMAPPED, VAL_RELEASE, 32'd200);
        tick_at(32'd5000);
    endtask

    // bounce, ignored press and releases, short press reported on the window edge
    task automatic test_short_press_and_bounce();
        send_request(REQ_KEY, KEY_ZERO, VAL_PRESS, 32'd1000);
        send_request(REQ_KEY, KEY_ZERO, VAL_RELEASE, 32'd1010);
        send_request(REQ_KEY, KEY_ZERO, VAL_PRESS, 32'd2000);
        send_request(REQ_KEY, KEY_ZERO, VAL_PRESS, 32'd2005);
        send_request(REQ_KEY, KEY_ZERO, VAL_RELEASE, 32'd2100);
        send_request(REQ_KEY, KEY_ZERO, VAL_RELEASE, 32'd2150);
        tick_at(32'd2399);
        tick_at(32'd2400);
        send_request(REQ_KEY, KEY_ZERO, VAL_RELEASE, 32'd2500);
    endtask

    // second press right on the window edge, then one just past it
    task automatic test_double_click();
        send_request(REQ_KEY, KEY_TOP, VAL_PRESS, 32'd3000);
        send_request(REQ_KEY, KEY_TOP, VAL_RELEASE, 32'd3100);
        send_request(REQ_KEY, KEY_TOP, VAL_PRESS, 32'd3400);
        send_request(REQ_KEY, KEY_TOP, VAL_PRESS, 32'd3401);
        send_request(REQ_KEY, KEY_TOP, VAL_RELEASE, 32'd3500);
        send_request(REQ_KEY, KEY_TOP, VAL_PRESS, 32'd3600);
        send_request(REQ_KEY, KEY_TOP, VAL_RELEASE, 32'd3700);
        send_request(REQ_KEY, KEY_TOP, VAL_PRESS, 32'd4001);
        send_request(REQ_KEY, KEY_TOP, VAL_RELEASE, 32'd4100);
        tick_at(32'd4400);
    endtask

    // slot made by value 3, two long presses from one tick, then quiet releases
    task automatic test_long_press();
        send_request(REQ_KEY, KEY_MID, VAL_SLOT_ONLY, 32'd4500);
        send_request(REQ_KEY, KEY_MID, VAL_PRESS, 32'd5000);
        send_request(REQ_KEY, KEY_TOP, VAL_PRESS, 32'd5000);
        tick_at(32'd5999);
        tick_at(32'd6000);
        send_request(REQ_KEY, KEY_MID, VAL_PRESS, 32'd6001);
        send_request(REQ_KEY, KEY_MID, VAL_RELEASE, 32'd6100);
        send_request(REQ_KEY, KEY_TOP, VAL_RELEASE, 32'd6200);
    endtask

    // release stamped before its press counts as zero hold, then long by release
    task automatic test_time_wrap();
        send_request(REQ_KEY, KEY_ODD, VAL_PRESS, 32'hFFFF_FFF0);
        send_request(REQ_KEY, KEY_ODD, VAL_RELEASE, 32'd16);
        send_request(REQ_KEY, KEY_ODD, VAL_PRESS, 32'd7000);
        send_request(REQ_KEY, KEY_ODD, VAL_RELEASE, 32'd8000);
    endtask

    // new map with a duplicate code, fill the table, then a code with no room
    task automatic test_slots_full();
        set_map({KEY_E, 8'h80}, {KEY_F, 8'h7F}, {KEY_G, 8'h33}, {KEY_E, 8'h44});
        send_request(REQ_KEY, KEY_E, VAL_PRESS, 32'd9000);
        send_request(REQ_KEY, KEY_F, VAL_PRESS, 32'd9000);
        send_request(REQ_KEY, KEY_G, VAL_SLOT_ONLY, 32'd9000);
        send_request(REQ_KEY, KEY_LATE, VAL_PRESS, 32'd9100);
        tick_at(32'd10000);
        send_request(REQ_KEY, KEY_E, VAL_RELEASE, 32'd10100);
        send_request(REQ_KEY, KEY_F, VAL_RELEASE, 32'd10100);
    endtask

    // one short random sequence on one key, or a stray request
    task automatic random_gesture();
        logic [CODE_W-1:0] code;
        code = key_pool[$urandom_range(8)];
        case ($urandom_range(9))
            0, 1, 2:
            begin
                key_later(code, VAL_PRESS);
                key_later(code, VAL_RELEASE);
                tick_later();
            end
            3, 4:
            begin
                key_later(code, VAL_PRESS);
                key_later(code, VAL_RELEASE);
                key_later(code, VAL_PRESS);
                key_later(code, VAL_RELEASE);
            end
            5, 6:
            begin
                key_later(code, VAL_PRESS);
                tick_later();
                key_later(code, VAL_RELEASE);
            end
            7:
                tick_later();
            8:
                key_later(code, 2'($urandom_range(3)));
            default:
                send_request(1'($urandom_range(1)), CODE_W'($urandom_range(767)),
                             2'($urandom_range(3)), $urandom());
        endcase
    endtask

    // one random phase: its own idling, its own windows, about n requests
    task automatic test_random(input int pct, input logic [15:0] l, input logic [15:0] d,
                               input logic [15:0] b, input int n, input bit pause_midway);
        int stop_at;
        int half_at;
        wait_quiet();
        set_timing(l, d, b);
        idle_pct = pct;
        stop_at = requests_sent + n;
        half_at = requests_sent + n / 2;
        while (requests_sent < stop_at)
        begin
            random_gesture();
            if (pause_midway && requests_sent >= half_at)
            begin
                // hold off until every gesture so far has come out
                wait_quiet();
                pause_midway = 1'b0;
            end
        end
    endtask

    // each strobe is compared with the oldest prediction
    always @(posedge clk)
    begin : check_gestures
        gesture_exp_t want;
        if (rst_n && result_valid)
        begin
            if (gesture_q.size() == 0)
                flag_error($sformatf("unexpected gesture: key %0d kind %0d hold %0d last %0b",
                                     gesture_key, gesture_kind, hold_ms, last_of_run));
            else
            begin
                want = gesture_q.pop_front();
                if (gesture_key !== want.key || gesture_kind !== want.kind ||
                    hold_ms !== want.hold || last_of_run !== want.last)
                    flag_error($sformatf({"gesture mismatch: expected key %0d kind %0d ",
                                          "hold %0d last %0b, got key %0d kind %0d ",
                                          "hold %0d last %0b"},
                                         want.key, want.kind, want.hold, want.last,
                                         gesture_key, gesture_kind, hold_ms, last_of_run));
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        errors = 0;
        requests_sent = 0;
        idle_pct = 0;
        now_ms = 32'd20000;
        long_ms = LONG_PRESS_RST;
        dbl_ms = DOUBLE_CLICK_RST;
        bounce_ms = DEBOUNCE_RST;
        slots_used = 0;
        foreach (map_regs[i])
            map_regs[i] = '0;
        foreach (slot_phase[i])
        begin
            slot_code[i] = '0;
            slot_id[i] = '0;
            slot_phase[i] = PH_IDLE;
            slot_press[i] = '0;
            slot_release[i] = '0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_KEY;
        key_code = '0;
        key_value = VAL_RELEASE;
        time_ms = '0;
        cfg_we = 1'b0;
        cfg_index = REG_LONG_PRESS;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        test_unmapped_and_repeat();
        wait_quiet();
        set_timing(LONG_PRESS_RST, DOUBLE_CLICK_RST, DEBOUNCE_RST);
        set_map({KEY_ZERO, 8'hFF}, {KEY_TOP, 8'h01}, {KEY_MID, 8'h5A}, {KEY_ODD, 8'hAA});
        test_short_press_and_bounce();
        test_double_click();
        test_long_press();
        test_time_wrap();
        wait_quiet();
        test_slots_full();

        // random part: no idling, heavy idling, both sides, then no idling again
        test_random(0, 16'($urandom_range(20, 2000)), 16'($urandom_range(500)),
                    16'($urandom_range(50)), 45, 1'b0);
        test_random(66, 16'hFFFF, 16'hFFFF, 16'h0000, 45, 1'b1);
        test_random(22, 16'h0000, 16'h0000, 16'hFFFF, 45, 1'b0);
        test_random(0, 16'($urandom_range(100, 1500)), 16'($urandom_range(100, 600)),
                    16'($urandom_range(10, 80)), 45, 1'b0);

        wait_quiet();
        if (gesture_q.size() != 0)
            flag_error($sformatf("%0d predicted gestures never came out", gesture_q.size()));
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
